[sv/ole_pkg.sv]
// Shared types and constants of the ordered list engine.
// Holds the item structs, mode codes, status codes and the sequencer states.
// No dependencies.
package ole_pkg;

    // The position fields are six bits and the count field seven, so the
    // capacity is fixed with them.
    localparam int CAPACITY = 64;

    localparam logic [3:0] MODE_INS_HEAD = 4'd0;
    localparam logic [3:0] MODE_INS_TAIL = 4'd1;
    localparam logic [3:0] MODE_INS_AT   = 4'd2;
    localparam logic [3:0] MODE_RM_HEAD  = 4'd3;
    localparam logic [3:0] MODE_RM_TAIL  = 4'd4;
    localparam logic [3:0] MODE_RM_AT    = 4'd5;
    localparam logic [3:0] MODE_READ     = 4'd6;
    localparam logic [3:0] MODE_REPLACE  = 4'd7;
    localparam logic [3:0] MODE_SEARCH   = 4'd8;
    localparam logic [3:0] MODE_COMPARE  = 4'd9;
    localparam logic [3:0] MODE_SWAP     = 4'd10;
    localparam logic [3:0] MODE_CLEAR    = 4'd11;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT,
        OP_RM_HEAD, OP_RM_TAIL, OP_RM_AT,
        OP_READ, OP_REPLACE, OP_SEARCH, OP_COMPARE, OP_SWAP, OP_CLEAR,
        OP_NOP
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_WR, S_INS_PUT, S_RM_RD, S_RM_WR,
        S_RD_ISS, S_RD_GET, S_SR_ISS, S_SR_GET,
        S_SW_A, S_SW_B, S_SW_WA, S_SW_WB, S_DONE
    } t_state;

    typedef struct packed {
        logic [3:0]          mode;
        logic [5:0]          position;
        logic [5:0]          other_position;
        logic signed [31:0]  value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]  read_value;
        logic                found;
        logic [1:0]          status;
        logic [6:0]          count;
    } t_out_item;

    typedef struct packed {
        t_op                 op;
        logic [5:0]          position;
        logic [5:0]          other_position;
        logic signed [31:0]  value;
    } t_cmd;

    function automatic t_op decode_mode(input logic [3:0] mode);
        t_op op;
        begin
            unique case (mode)
                MODE_INS_HEAD: op = OP_INS_HEAD;
                MODE_INS_TAIL: op = OP_INS_TAIL;
                MODE_INS_AT:   op = OP_INS_AT;
                MODE_RM_HEAD:  op = OP_RM_HEAD;
                MODE_RM_TAIL:  op = OP_RM_TAIL;
                MODE_RM_AT:    op = OP_RM_AT;
                MODE_READ:     op = OP_READ;
                MODE_REPLACE:  op = OP_REPLACE;
                MODE_SEARCH:   op = OP_SEARCH;
                MODE_COMPARE:  op = OP_COMPARE;
                MODE_SWAP:     op = OP_SWAP;
                MODE_CLEAR:    op = OP_CLEAR;
                default:       op = OP_NOP;
            endcase
            return op;
        end
    endfunction

endpackage

[sv/ole_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

[sv/ole_front.sv]
// Front end of the ordered list engine: accepts items, decodes the mode
// and holds them in a two-entry queue for the sequencer. Uses ole_pkg.
module ole_front import ole_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_fill;
    logic       push;

    assign o_in_stall  = (r_fill == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + {1'b0, push} - {1'b0, i_cmd_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: decode_mode(i_in_item.mode),
                           position: i_in_item.position,
                           other_position: i_in_item.other_position,
                           value: i_in_item.value};
        end
    end
endmodule

[sv/ole_back.sv]
// Back end of the ordered list engine: a sequencer that carries out one
// list operation at a time on the entry RAM. Uses ole_pkg and ole_ram.
module ole_back import ole_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 6) ? CW : 6;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_tgt, n_tgt;
    logic [AW-1:0]         r_pos2, n_pos2;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [DATA_WIDTH-1:0] r_tmp, n_tmp;
    logic signed [31:0]    r_rd, n_rd;
    logic                  r_found, n_found;
    t_status               r_status, n_status;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;
    logic                  r_is_read;

    logic                  we, re;
    logic [AW-1:0]         waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata, rdata;

    logic [XW-1:0]         pos_x, pos2_x, cnt_x, tgt_x;
    logic [DATA_WIDTH-1:0] cmd_val;
    logic                  full;
    logic [AW-1:0]         last;

    ole_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign pos_x   = XW'(i_cmd.position);
    assign pos2_x  = XW'(i_cmd.other_position);
    assign cnt_x   = XW'(r_count);
    assign cmd_val = DATA_WIDTH'(64'(i_cmd.value));
    assign full    = (r_count >= CW'(CAPACITY));
    assign last    = AW'(r_count - CW'(1));

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_tgt       = r_tgt;
        n_pos2      = r_pos2;
        n_val       = r_val;
        n_tmp       = r_tmp;
        n_rd        = r_rd;
        n_found     = r_found;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        we          = 1'b0;
        waddr       = r_idx;
        wdata       = rdata;
        re          = 1'b0;
        raddr       = r_idx;
        tgt_x       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_rd      = '0;
                    n_found   = 1'b0;
                    n_status  = ST_OK;
                    n_val     = cmd_val;
                    n_tgt     = AW'(pos_x);
                    n_pos2    = AW'(pos2_x);
                    n_state   = S_DONE;
                    unique case (i_cmd.op)
                        OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
                            priority if (i_cmd.op == OP_INS_HEAD) begin
                                tgt_x = '0;
                            end else if (i_cmd.op == OP_INS_TAIL) begin
                                tgt_x = cnt_x;
                            end else begin
                                tgt_x = pos_x;
                            end
                            n_tgt = AW'(tgt_x);
                            n_idx = last;
                            priority if (tgt_x > cnt_x) begin
                                n_status = ST_RANGE;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else if (tgt_x == cnt_x) begin
                                n_state = S_INS_PUT;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        OP_RM_HEAD, OP_RM_TAIL: begin
                            n_idx = (i_cmd.op == OP_RM_HEAD) ? '0 : last;
                            priority if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (i_cmd.op == OP_RM_TAIL || r_count == CW'(1)) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_state = S_RM_RD;
                            end
                        end
                        OP_RM_AT: begin
                            n_idx = AW'(pos_x);
                            priority if (pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                            end else if (AW'(pos_x) == last) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_state = S_RM_RD;
                            end
                        end
                        OP_READ, OP_COMPARE: begin
                            n_idx = AW'(pos_x);
                            if (pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_state = S_RD_ISS;
                            end
                        end
                        OP_REPLACE: begin
                            if (pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                we    = 1'b1;
                                waddr = AW'(pos_x);
                                wdata = cmd_val;
                            end
                        end
                        OP_SEARCH: begin
                            n_idx = '0;
                            if (r_count != '0) begin
                                n_state = S_SR_ISS;
                            end
                        end
                        OP_SWAP: begin
                            if (pos_x >= cnt_x || pos2_x >= cnt_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_state = S_SW_A;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Shift entries up from the tail down to the insert point.
            S_INS_RD: begin
                re      = 1'b1;
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                we    = 1'b1;
                waddr = r_idx + AW'(1);
                if (r_idx == r_tgt) begin
                    n_state = S_INS_PUT;
                end else begin
                    n_idx   = r_idx - AW'(1);
                    n_state = S_INS_RD;
                end
            end
            S_INS_PUT: begin
                we      = 1'b1;
                waddr   = r_tgt;
                wdata   = r_val;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            // Shift entries down over the removed one.
            S_RM_RD: begin
                re      = 1'b1;
                raddr   = r_idx + AW'(1);
                n_state = S_RM_WR;
            end
            S_RM_WR: begin
                we = 1'b1;
                if (r_idx + AW'(1) == last) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_RM_RD;
                end
            end
            S_RD_ISS: begin
                re      = 1'b1;
                n_state = S_RD_GET;
            end
            // Only a read returns a value; only a compare sets found.
            S_RD_GET: begin
                if (r_is_read) begin
                    n_rd = 32'(64'($signed(rdata)));
                end else if (r_val == rdata) begin
                    n_found = 1'b1;
                end
                n_state = S_DONE;
            end
            S_SR_ISS: begin
                re      = 1'b1;
                n_state = S_SR_GET;
            end
            S_SR_GET: begin
                priority if (r_val == rdata) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else if (r_idx == last) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_SR_ISS;
                end
            end
            S_SW_A: begin
                re      = 1'b1;
                raddr   = r_tgt;
                n_state = S_SW_B;
            end
            S_SW_B: begin
                re      = 1'b1;
                raddr   = r_pos2;
                n_tmp   = rdata;
                n_state = S_SW_WA;
            end
            S_SW_WA: begin
                we      = 1'b1;
                waddr   = r_tgt;
                n_state = S_SW_WB;
            end
            S_SW_WB: begin
                we      = 1'b1;
                waddr   = r_pos2;
                wdata   = r_tmp;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = '{read_value: r_rd, found: r_found,
                                    status: r_status, count: 7'(r_count)};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_tgt    <= n_tgt;
        r_pos2   <= n_pos2;
        r_val    <= n_val;
        r_tmp    <= n_tmp;
        r_rd     <= n_rd;
        r_found  <= n_found;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // Read and compare share the fetch path; this tells them apart.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_is_read <= (i_cmd.op == OP_READ);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");
    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_PUT) |-> (r_count < CW'(CAPACITY)))
        else $error("insert started on a full list");
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SR_GET) |-> (CW'(r_idx) < r_count))
        else $error("search walked past the tail");
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> r_out_valid)
        else $error("finished item not presented");
endmodule

[sv/ordered_list_engine.sv]
// Ordered list engine: keeps an ordered list of up to CAPACITY signed values
// and applies one list operation per input item, giving one result item each.
//
// Channels: input items on i_in_valid / o_in_stall / i_in_item, result items
// on o_out_valid / i_out_stall / o_out_item. An item moves at a rising edge
// where valid is high and stall is low. A two-entry queue after the decoder
// lets items be accepted while the sequencer is busy or a result waits.
//
// Steps after the item reaches the sequencer: clear, replace, remove at the
// tail and failed checks go straight to the result; read and compare read
// one entry; swap reads both entries, then writes both; insert at index k
// moves each entry from the tail down to k up one place by a read and a
// write, then stores the value; remove at index k moves each later entry
// down one place; search reads from the head until a match or the tail.
//
// Reset clears the count, the queue and the output valid flag; stored values
// are left as they are. When the receiver stalls, the result is held and the
// sequencer waits before presenting the next one, while the queue fills.
module ordered_list_engine import ole_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);
    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    ole_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    ole_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );
endmodule
